@@ rtl/tco_pkg.sv @@
// Shared types, constants and the trit combining table for the crazy-operation block.
`timescale 1ns / 1ps

package tco_pkg;

  localparam int WORD_W      = 23;
  localparam int COUNT_W     = 4;
  localparam int PROD_W      = 48;
  localparam int RECIP_SHIFT = 25;

  // ceil(2^25 / 3): exact quotient for any 23-bit dividend
  localparam logic [PROD_W-1:0] RECIP3 = PROD_W'(64'd11184811);

  localparam logic [COUNT_W-1:0] TRIT_COUNT_RESET = COUNT_W'(10);

  typedef logic [1:0] trit_t;

  typedef struct packed {
    logic               vld;
    logic [COUNT_W-1:0] cnt;
    logic [WORD_W-1:0]  d;
    logic [WORD_W-1:0]  a;
    logic [WORD_W-1:0]  acc;
  } tco_beat_t;

  function automatic trit_t crazy(input trit_t d, input trit_t a);
    trit_t r;
    unique case ({d, a})
      4'b00_00: r = 2'd1;
      4'b01_00: r = 2'd1;
      4'b01_10: r = 2'd2;
      4'b10_00: r = 2'd2;
      4'b10_01: r = 2'd2;
      4'b10_10: r = 2'd1;
      default:  r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic longint unsigned pow3(input int n);
    longint unsigned p;
    p = 64'd1;
    for (int i = 0; i < n; i++) begin
      p = p * 64'd3;
    end
    return p;
  endfunction

endpackage

@@ rtl/tco_cell.sv @@
// One trit cell: peels the low trit off both operands and adds its weighted result if its index is below the count.
`timescale 1ns / 1ps

module tco_cell #(
  parameter int IDX = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  tco_pkg::tco_beat_t in_beat,
  output tco_pkg::tco_beat_t out_beat
);
  import tco_pkg::*;

  localparam logic [WORD_W-1:0] PLACE = WORD_W'(pow3(IDX));
  localparam logic [COUNT_W:0]  IDX_C = (COUNT_W + 1)'(IDX);

  logic [PROD_W-1:0] prod_d, prod_a;
  logic [WORD_W-1:0] q_d, q_a;
  logic [WORD_W:0]   rem_d, rem_a;
  trit_t             t;
  logic              active;
  logic [WORD_W-1:0] term;
  tco_beat_t         out_next;

  always_comb begin
    prod_d = PROD_W'(in_beat.d) * RECIP3;
    prod_a = PROD_W'(in_beat.a) * RECIP3;
    q_d    = prod_d[RECIP_SHIFT +: WORD_W];
    q_a    = prod_a[RECIP_SHIFT +: WORD_W];
    rem_d  = {1'b0, in_beat.d} - {q_d, 1'b0} - {1'b0, q_d};
    rem_a  = {1'b0, in_beat.a} - {q_a, 1'b0} - {1'b0, q_a};
    t      = crazy(rem_d[1:0], rem_a[1:0]);
    active = IDX_C < {1'b0, in_beat.cnt};
    case (t)
      2'd1:    term = PLACE;
      2'd2:    term = {PLACE[WORD_W-2:0], 1'b0};
      default: term = '0;
    endcase
    out_next     = in_beat;
    out_next.d   = q_d;
    out_next.a   = q_a;
    out_next.acc = active ? in_beat.acc + term : in_beat.acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_beat <= '0;
    end else begin
      out_beat <= out_next;
    end
  end

endmodule

@@ rtl/ternary_crazy_op_top.sv @@
// Top level: trit-count register and the chain of trit cells.
// An accepted start is registered in each cell of the chain in turn before it shows as the result_valid strobe.
// Throughput: one operand pair per cycle; busy never rises, one cell per trit.
// Reset: synchronous, active high; empties the chain and sets trit_count to 10.
// The receiver cannot stall: each result shows for exactly one cycle.
`timescale 1ns / 1ps

module ternary_crazy_op_top #(
  parameter int MAX_TRITS = 14
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [tco_pkg::WORD_W-1:0]   data_word,
  input  logic [tco_pkg::WORD_W-1:0]   accumulator_word,
  input  logic                         cfg_we,
  input  logic [tco_pkg::COUNT_W-1:0]  cfg_data,
  output logic                         result_valid,
  output logic [tco_pkg::WORD_W-1:0]   result_word
);
  import tco_pkg::*;

  logic [COUNT_W-1:0] trit_count;
  tco_beat_t          chain [MAX_TRITS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      trit_count <= TRIT_COUNT_RESET;
    end else if (cfg_we) begin
      trit_count <= cfg_data;
    end
  end

  assign busy = 1'b0;

  always_comb begin
    chain[0].vld = start & ~busy;
    chain[0].cnt = trit_count;
    chain[0].d   = data_word;
    chain[0].a   = accumulator_word;
    chain[0].acc = '0;
  end

  for (genvar i = 0; i < MAX_TRITS; i++) begin : g_cell
    tco_cell #(.IDX(i)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_beat  (chain[i]),
      .out_beat (chain[i+1])
    );
  end

  assign result_valid = chain[MAX_TRITS].vld;
  assign result_word  = chain[MAX_TRITS].acc;

endmodule

@@ rtl/tco_check.sv @@
// Port-level checker for the crazy-operation block, bound to the top level.
`timescale 1ns / 1ps

module tco_check #(
  parameter int MAX_TRITS = 14
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        result_valid,
  input logic [tco_pkg::WORD_W-1:0]  result_word
);

  localparam int AGE_W = $clog2(MAX_TRITS + 2);

  logic [AGE_W-1:0] age;

  always_ff @(posedge clk) begin
    if (rst) begin
      age <= '0;
    end else if (age <= AGE_W'(MAX_TRITS)) begin
      age <= age + AGE_W'(1);
    end
  end

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(start, MAX_TRITS))
    else $error("result beat without a matching start");

  a_no_lost: assert property (@(posedge clk) disable iff (rst)
    (age > AGE_W'(MAX_TRITS)) && $past(start, MAX_TRITS) |-> result_valid)
    else $error("accepted beat produced no result");

  a_quiet_after_reset: assert property (@(posedge clk) disable iff (rst)
    (age < AGE_W'(MAX_TRITS)) |-> !result_valid)
    else $error("result beat too soon after reset");

  a_known_result: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !$isunknown(result_word))
    else $error("result beat carries unknown bits");

endmodule

bind ternary_crazy_op_top tco_check #(.MAX_TRITS(MAX_TRITS)) u_tco_check (
  .clk              (clk),
  .rst              (rst),
  .start            (start),
  .busy             (busy),
  .result_valid     (result_valid),
  .result_word      (result_word)
);

@@ bench/testbench.sv @@
// Self-checking bench for the crazy-operation block: directed table, random phases, predictor.
`timescale 1ns / 1ps

module testbench;

  import tco_pkg::*;

  localparam int TRIT_LIMIT = 14;
  localparam int NUM_DIR = 22;
  localparam int NUM_PHASES = 16;
  localparam int ITEMS_PER_PHASE = 100;
  localparam logic [WORD_W-1:0] ALL_TWOS = WORD_W'(4782968);
  localparam logic [WORD_W-1:0] ALL_ONES = {WORD_W{1'b1}};
  // result trit for data trit d and accumulator trit a, indexed by 3*d + a
  localparam logic [17:0] CRAZY_LUT = {2'd1, 2'd2, 2'd2, 2'd2, 2'd0, 2'd1, 2'd0, 2'd0, 2'd1};

  typedef struct packed {
    logic [COUNT_W-1:0] cnt;
    logic [WORD_W-1:0]  d;
    logic [WORD_W-1:0]  a;
    logic               typed;
    logic [WORD_W-1:0]  res;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic [WORD_W-1:0]   data_word = '0;
  logic [WORD_W-1:0]   accumulator_word = '0;
  logic                cfg_we = 1'b0;
  logic [COUNT_W-1:0]  cfg_data = '0;
  logic                result_valid;
  logic [WORD_W-1:0]   result_word;

  logic [WORD_W-1:0]   pending_results[$];
  logic [COUNT_W-1:0]  trit_count_q = TRIT_COUNT_RESET;
  dir_row_t            dir_tab[NUM_DIR];
  int                  fail_count = 0;

  ternary_crazy_op_top #(
    .MAX_TRITS(TRIT_LIMIT)
  ) u_top (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .data_word        (data_word),
    .accumulator_word (accumulator_word),
    .cfg_we           (cfg_we),
    .cfg_data         (cfg_data),
    .result_valid     (result_valid),
    .result_word      (result_word)
  );

  always #4 clk = ~clk;

  function automatic logic [WORD_W-1:0] crazy_result(input logic [WORD_W-1:0] d,
                                                     input logic [WORD_W-1:0] a,
                                                     input logic [COUNT_W-1:0] cnt);
    int unsigned dv;
    int unsigned av;
    int unsigned n;
    int unsigned place;
    int unsigned sum;
    int unsigned idx;
    dv = 32'(d);
    av = 32'(a);
    n = (cnt > TRIT_LIMIT) ? TRIT_LIMIT : 32'(cnt);
    place = 1;
    sum = 0;
    for (int i = 0; i < n; i++) begin
      idx = (dv % 3) * 3 + (av % 3);
      sum += 32'(CRAZY_LUT[2*idx +: 2]) * place;
      dv /= 3;
      av /= 3;
      place *= 3;
    end
    return sum[WORD_W-1:0];
  endfunction

  function automatic logic [WORD_W-1:0] rand_operand();
    logic [WORD_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = WORD_W'($urandom());
      1: v = WORD_W'($urandom_range(4782969, 8388607));
      2: v = ALL_TWOS;
      3: v = '0;
      4: v = ALL_ONES;
      default: v = WORD_W'($urandom_range(0, 4782968));
    endcase
    return v;
  endfunction

  task automatic send_beat(input logic [WORD_W-1:0] d, input logic [WORD_W-1:0] a,
                           input logic typed, input logic [WORD_W-1:0] res, input int gap);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    data_word <= d;
    accumulator_word <= a;
    do @(posedge clk); while (busy);
    pending_results.push_back(typed ? res : crazy_result(d, a, trit_count_q));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_trit_count(input logic [COUNT_W-1:0] v);
    wait_drained();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    trit_count_q = v;
  endtask

  always @(posedge clk) begin
    logic [WORD_W-1:0] want;
    if (!rst && result_valid) begin
      if (pending_results.size() == 0) begin
        $error("result_word: unexpected beat, actual %0d", result_word);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (result_word !== want) begin
          $error("result_word: expected %0d, actual %0d", want, result_word);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #2ms;
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [COUNT_W-1:0] cnt;
    bit                 burst;
    dir_tab[0]  = '{4'd10, 23'd0, 23'd0, 1'b1, 23'd29524};
    dir_tab[1]  = '{4'd10, ALL_TWOS, ALL_TWOS, 1'b0, 23'd0};
    dir_tab[2]  = '{4'd14, 23'd0, 23'd0, 1'b1, 23'd2391484};
    dir_tab[3]  = '{4'd14, ALL_TWOS, ALL_TWOS, 1'b1, 23'd2391484};
    dir_tab[4]  = '{4'd14, ALL_TWOS, 23'd0, 1'b1, ALL_TWOS};
    dir_tab[5]  = '{4'd14, 23'd0, ALL_TWOS, 1'b1, 23'd0};
    dir_tab[6]  = '{4'd14, ALL_ONES, ALL_ONES, 1'b0, 23'd0};
    dir_tab[7]  = '{4'd15, 23'd0, 23'd0, 1'b1, 23'd2391484};
    dir_tab[8]  = '{4'd15, ALL_ONES, 23'd0, 1'b0, 23'd0};
    dir_tab[9]  = '{4'd0, 23'd0, 23'd0, 1'b1, 23'd0};
    dir_tab[10] = '{4'd0, ALL_ONES, ALL_ONES, 1'b1, 23'd0};
    for (int i = 0; i < 9; i++) begin
      dir_tab[11+i] = '{4'd1, WORD_W'(i / 3 + 15), WORD_W'(i % 3 + 21), 1'b0, 23'd0};
    end
    dir_tab[20] = '{4'd1, 23'd3, 23'd0, 1'b1, 23'd1};
    dir_tab[21] = '{4'd2, 23'd8, 23'd4, 1'b1, 23'd8};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_DIR; i++) begin
      if (dir_tab[i].cnt != trit_count_q) set_trit_count(dir_tab[i].cnt);
      send_beat(dir_tab[i].d, dir_tab[i].a, dir_tab[i].typed, dir_tab[i].res,
                $urandom_range(0, 3));
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: cnt = 4'd14;
        1: cnt = 4'd15;
        2: cnt = 4'd0;
        3: cnt = 4'd1;
        4: cnt = 4'd10;
        default: cnt = COUNT_W'($urandom_range(0, 15));
      endcase
      set_trit_count(cnt);
      burst = ($urandom_range(0, 3) == 0);
      for (int j = 0; j < ITEMS_PER_PHASE; j++) begin
        // occasional hold-off until the pipe is empty
        if ($urandom_range(0, 49) == 0) wait_drained();
        send_beat(rand_operand(), rand_operand(), 1'b0, '0,
                  burst ? 0 : $urandom_range(0, 15));
      end
    end

    wait_drained();
    repeat (TRIT_LIMIT + 4) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("result_word: %0d beats never arrived", pending_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
